// ===== hw/rtl/dct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dct_pkg
// Shared types and constants of the delimiter class tokenizer.
// ----------------------------------------------------------------------------
package dct_pkg;

   localparam int NUM_CLASSES      = 2;
   localparam int RANGES_PER_SET   = 4;
   localparam int MAX_NESTING_DEF  = 255;

   // Only two classes and four ranges fit in the register map.
   localparam int CHECKED_CLASSES  = (NUM_CLASSES < 2) ? NUM_CLASSES : 2;
   localparam int CHECKED_RANGES   = (RANGES_PER_SET < 4) ? RANGES_PER_SET : 4;

   localparam int SET_W            = 64;
   localparam int CHAR_W           = 8;
   localparam int CSR_INDEX_W      = 3;

   localparam logic [SET_W-1:0]  SET_RESET    = 64'hFF00_FF00_FF00_FF00;
   localparam logic [7:0]        FLAGS_RESET  = 8'h00;
   localparam logic [1:0]        ACTIVE_RESET = 2'd1;

   localparam logic [CHAR_W-1:0] QUOTE_CHAR   = 8'd34;

   // Bit positions within one class's flag group
   localparam logic [1:0] FLAG_HAS_END    = 2'd0;
   localparam logic [1:0] FLAG_EXCL_START = 2'd1;
   localparam logic [1:0] FLAG_EXCL_END   = 2'd2;
   localparam logic [1:0] FLAG_NEST       = 2'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_A = 3'd0,
      REG_END_A   = 3'd1,
      REG_START_B = 3'd2,
      REG_END_B   = 3'd3,
      REG_FLAGS   = 3'd4,
      REG_QUOTE   = 3'd5,
      REG_ACTIVE  = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [1:0][SET_W-1:0] start_set;
      logic [1:0][SET_W-1:0] end_set;
      logic [7:0]            class_flags;
      logic                  quote_enable;
      logic [1:0]            active_classes;
   } cfg_type;

   typedef struct packed {
      logic              has_char;
      logic [CHAR_W-1:0] token_char;
      logic              class_index;
      logic              token_end;
      logic              failed;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dct_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dct_csr
// Configuration registers: class sets, flags, quote mode and class count.
// ----------------------------------------------------------------------------
module dct_csr
   import dct_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [SET_W-1:0]       csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_reg_type'(csr_index))
            REG_START_A: cfg_in.start_set[0]   = csr_wdata;
            REG_END_A:   cfg_in.end_set[0]     = csr_wdata;
            REG_START_B: cfg_in.start_set[1]   = csr_wdata;
            REG_END_B:   cfg_in.end_set[1]     = csr_wdata;
            REG_FLAGS:   cfg_in.class_flags    = csr_wdata[7:0];
            REG_QUOTE:   cfg_in.quote_enable   = csr_wdata[0];
            REG_ACTIVE:  cfg_in.active_classes = csr_wdata[1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_set      <= {SET_RESET, SET_RESET};
         cfg_ff.end_set        <= {SET_RESET, SET_RESET};
         cfg_ff.class_flags    <= FLAGS_RESET;
         cfg_ff.quote_enable   <= 1'b0;
         cfg_ff.active_classes <= ACTIVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/dct_set_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dct_set_match
// Tests one character against a set of low/high byte ranges.
// ----------------------------------------------------------------------------
module dct_set_match
   import dct_pkg::*;
(
   input  wire logic [SET_W-1:0]  set_bits,
   input  wire logic [CHAR_W-1:0] ch,
   output logic                   hit
);

   logic [CHECKED_RANGES-1:0] range_hit;

   for (genvar r = 0; r < CHECKED_RANGES; r++) begin : g_range
      logic [CHAR_W-1:0] lo;
      logic [CHAR_W-1:0] hi;
      assign lo           = set_bits[16*r+8 +: CHAR_W];
      assign hi           = set_bits[16*r   +: CHAR_W];
      // an inverted range never matches
      assign range_hit[r] = (lo <= ch) && (ch <= hi);
   end

   assign hit = |range_hit;

endmodule
`default_nettype wire

// ===== hw/rtl/dct_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dct_engine
// Token state and the per-character decision: open, extend, close, fail or drop.
// ----------------------------------------------------------------------------
module dct_engine
   import dct_pkg::*;
#(
   parameter int MAX_NESTING = MAX_NESTING_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [CHAR_W-1:0] text_char,
   input  wire logic              last_in_buffer,
   input  wire cfg_type           cfg,
   output logic                   res_valid,
   output rsp_type                res
);

   localparam int NEST_W = $clog2(MAX_NESTING + 1);
   localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NESTING);

   logic              in_token_ff, in_token_in;
   logic              open_class_ff, open_class_in;
   logic [NEST_W-1:0] nest_ff, nest_in;
   logic              quote_ff, quote_in;

   logic [1:0]        start_hit;
   logic [1:0]        end_hit;
   logic              quote_next;
   logic              hit0, hit1, hit_any, hit_cls;
   logic              cls;
   logic              nest_up, end_match;
   logic [NEST_W-1:0] nest_raised;
   logic              keep;

   function automatic logic flag_of(input logic [7:0] flags, input logic c,
                                    input logic [1:0] b);
      return flags[{c, b}];
   endfunction

   for (genvar i = 0; i < 2; i++) begin : g_class
      dct_set_match u_start (
         .set_bits (cfg.start_set[i]),
         .ch       (text_char),
         .hit      (start_hit[i])
      );
      dct_set_match u_end (
         .set_bits (cfg.end_set[i]),
         .ch       (text_char),
         .hit      (end_hit[i])
      );
   end

   always_comb begin
      quote_next = quote_ff ^ (cfg.quote_enable && (text_char == QUOTE_CHAR));

      // class priority: lower index wins
      hit0    = (cfg.active_classes != 2'd0) && start_hit[0] && !quote_next;
      hit1    = (CHECKED_CLASSES > 1) && cfg.active_classes[1] && start_hit[1]
                && !quote_next && !hit0;
      hit_any = hit0 || hit1;
      hit_cls = hit1;

      cls         = open_class_ff;
      nest_up     = !quote_next && flag_of(cfg.class_flags, cls, FLAG_NEST)
                    && start_hit[cls];
      nest_raised = nest_ff + NEST_W'(nest_up && (nest_ff < NEST_MAX));
      end_match   = !quote_next && end_hit[cls];

      keep = 1'b0;

      in_token_in   = in_token_ff;
      open_class_in = open_class_ff;
      nest_in       = nest_ff;
      quote_in      = quote_ff;

      res_valid       = 1'b0;
      res.has_char    = 1'b0;
      res.token_char  = '0;
      res.class_index = 1'b0;
      res.token_end   = 1'b0;
      res.failed      = 1'b0;

      if (advance) begin
         if (!in_token_ff) begin
            if (hit_any) begin
               keep            = !flag_of(cfg.class_flags, hit_cls, FLAG_EXCL_START);
               res.class_index = hit_cls;
               if (!flag_of(cfg.class_flags, hit_cls, FLAG_HAS_END)) begin
                  // one-character token
                  res_valid     = 1'b1;
                  res.has_char  = keep;
                  res.token_end = 1'b1;
                  in_token_in   = 1'b0;
                  open_class_in = 1'b0;
                  nest_in       = '0;
                  quote_in      = 1'b0;
               end else if (last_in_buffer) begin
                  res_valid     = 1'b1;
                  res.failed    = 1'b1;
                  in_token_in   = 1'b0;
                  open_class_in = 1'b0;
                  nest_in       = '0;
                  quote_in      = 1'b0;
               end else begin
                  res_valid     = keep;
                  res.has_char  = keep;
                  in_token_in   = 1'b1;
                  open_class_in = hit_cls;
                  nest_in       = '0;
                  quote_in      = quote_next;
               end
            end else if (last_in_buffer) begin
               res_valid     = 1'b1;
               res.failed    = 1'b1;
               in_token_in   = 1'b0;
               open_class_in = 1'b0;
               nest_in       = '0;
               quote_in      = 1'b0;
            end else begin
               // drop scanning character
               quote_in = quote_next;
            end
         end else begin
            res_valid       = 1'b1;
            res.class_index = cls;
            if (end_match && (nest_raised == '0)) begin
               res.has_char  = !flag_of(cfg.class_flags, cls, FLAG_EXCL_END);
               res.token_end = 1'b1;
               in_token_in   = 1'b0;
               open_class_in = 1'b0;
               nest_in       = '0;
               quote_in      = 1'b0;
            end else if (last_in_buffer) begin
               res.failed    = 1'b1;
               in_token_in   = 1'b0;
               open_class_in = 1'b0;
               nest_in       = '0;
               quote_in      = 1'b0;
            end else begin
               res.has_char = 1'b1;
               nest_in      = end_match ? (nest_raised - NEST_W'(1)) : nest_raised;
               quote_in     = quote_next;
            end
         end
         res.token_char = res.has_char ? text_char : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff   <= 1'b0;
         open_class_ff <= 1'b0;
         nest_ff       <= '0;
         quote_ff      <= 1'b0;
      end else begin
         in_token_ff   <= in_token_in;
         open_class_ff <= open_class_in;
         nest_ff       <= nest_in;
         quote_ff      <= quote_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/delimiter_class_tokenizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delimiter_class_tokenizer_core
// Character-stream tokenizer with prioritized delimiter classes, nesting
// and quote suppression.
// ----------------------------------------------------------------------------
// Path: request to response passes the input register, then the result register.
// Throughput: 1 character per cycle, set by the token state update, barring a response stall.
// A stalled response holds the input register; the next request waits behind it.
// Reset: synchronous; clears token state, the valid flags of both pipeline registers and the
// configuration to its reset values (empty sets, one active class).
module delimiter_class_tokenizer_core
   import dct_pkg::*;
#(
   parameter int MAX_NESTING = MAX_NESTING_DEF
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [CHAR_W-1:0]      req_text_char,
   input  wire logic                   req_last_in_buffer,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_has_char,
   output logic [CHAR_W-1:0]           rsp_token_char,
   output logic                        rsp_class_index,
   output logic                        rsp_token_end,
   output logic                        rsp_failed,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [SET_W-1:0]       csr_wdata
);

   cfg_type           cfg;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic              advance;
   logic              res_valid;
   rsp_type           res;

   dct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // process the held request when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   dct_engine #(
      .MAX_NESTING (MAX_NESTING)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .text_char      (in_char_ff),
      .last_in_buffer (in_last_ff),
      .cfg            (cfg),
      .res_valid      (res_valid),
      .res            (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_text_char;
         in_last_ff <= req_last_in_buffer;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_has_char    = rsp_ff.has_char;
   assign rsp_token_char  = rsp_ff.token_char;
   assign rsp_class_index = rsp_ff.class_index;
   assign rsp_token_end   = rsp_ff.token_end;
   assign rsp_failed      = rsp_ff.failed;

`ifndef NO_ASSERTIONS
   // the last character of a buffer always closes or fails
   a_last_resolves: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (rsp_valid && (rsp_token_end || rsp_failed)))
      else $error("last character produced no closing response");

   // a response always carries something
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_char || rsp_token_end || rsp_failed))
      else $error("empty response delivered");

   // a failure never carries a character
   a_fail_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_failed) |-> (!rsp_has_char && !rsp_token_end
                                     && (rsp_token_char == '0)))
      else $error("failed response carries token data");
`endif

endmodule
`default_nettype wire
